[rtl/cyclic_relay_timer_with_overrides_macros.svh]
// assertion macros used by the rtl
`ifndef CYCLIC_RELAY_TIMER_WITH_OVERRIDES_MACROS_SVH
`define CYCLIC_RELAY_TIMER_WITH_OVERRIDES_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the next cycle
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define CRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define CRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/crt_pkg.sv]
`timescale 1ns / 1ps

package crt_pkg;

    localparam int KnobWidth      = 12;
    localparam int ThresholdWidth = 11;
    localparam int HighCountWidth = 19;
    localparam int LowCountWidth  = 13;
    localparam int RelayCount     = 5;
    localparam int CfgIndexWidth  = 1;
    localparam int CfgDataWidth   = ThresholdWidth;

    // on period = knob * 83 / 50, done as knob * OnScale >> OnShift
    localparam int OnShift = 20;
    localparam logic [20:0] OnScale = 21'd1740637;
    localparam logic [6:0] OffScale = 7'd120;

    localparam logic [HighCountWidth-1:0] HighCountReset = 19'd10;
    localparam logic [LowCountWidth-1:0]  LowCountReset  = 13'd10;
    localparam logic [ThresholdWidth-1:0] ThresholdReset = 11'd30;

    localparam int RelayOne   = 0;
    localparam int RelayTwo   = 1;
    localparam int RelayThree = 2;
    localparam int RelayFour  = 3;
    localparam int RelayFive  = 4;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_AUTO_ENABLE     = 1'b0,
        CFG_DELAY_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [KnobWidth-1:0] on_knob;
        logic [KnobWidth-1:0] off_knob;
        logic [KnobWidth-1:0] delay_knob;
        logic                 sensor_one_level;
        logic                 sensor_two_level;
    } tick_t;

endpackage

[rtl/crt_tick_if.sv]
`timescale 1ns / 1ps

interface crt_tick_if;
    import crt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KnobWidth-1:0] on_knob;
    logic [KnobWidth-1:0] off_knob;
    logic [KnobWidth-1:0] delay_knob;
    logic                 sensor_one_level;
    logic                 sensor_two_level;

    modport source (
        output valid, on_knob, off_knob, delay_knob, sensor_one_level, sensor_two_level,
        input  ready
    );

    modport sink (
        input  valid, on_knob, off_knob, delay_knob, sensor_one_level, sensor_two_level,
        output ready
    );
endinterface

[rtl/crt_relay_if.sv]
`timescale 1ns / 1ps

interface crt_relay_if;
    logic valid;
    logic ready;
    logic relay_one;
    logic relay_two;
    logic relay_three;
    logic relay_four;
    logic relay_five;

    modport source (
        output valid, relay_one, relay_two, relay_three, relay_four, relay_five,
        input  ready
    );

    modport sink (
        input  valid, relay_one, relay_two, relay_three, relay_four, relay_five,
        output ready
    );
endinterface

[rtl/cyclic_relay_timer_with_overrides.sv]
`timescale 1ns / 1ps
// Cyclic relay timer with sensor overrides. Each request on tick carries three knob readings
// and two active-low sensor levels and yields exactly one request on result with the five
// relay levels after that tick. A tick is taken every clock cycle unless result is stalled;
// it passes through the tick register and then the relay state register, which doubles as
// the result register, and a stalled result holds the tick register and then tick.ready. In
// auto mode, with neither sensor active on the previous tick, relays one to three follow a
// two-phase cycle whose counters reload from off_knob*120 (high phase) and on_knob*1.66
// truncated (low phase). Sensor one forces relay three on and runs a delay count up to
// delay_knob/2; relay four is on while that count is at or above delay_threshold. Sensor
// two forces relays one, two and five on. Registers are written through cfg_wr_en,
// cfg_index and cfg_data: index 0 is auto_enable (reset 1), index 1 is delay_threshold
// (reset 30); write them only while no tick is in flight.
`include "cyclic_relay_timer_with_overrides_macros.svh"

module cyclic_relay_timer_with_overrides (
    input  logic                             clk,
    input  logic                             rst_n,
    crt_tick_if.sink                         tick,
    crt_relay_if.source                      result,
    input  logic                             cfg_wr_en,
    input  logic [crt_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [crt_pkg::CfgDataWidth-1:0]  cfg_data
);
    import crt_pkg::*;

    logic                      auto_enable_reg;
    logic [ThresholdWidth-1:0] delay_threshold_reg;

    tick_t tick_reg;
    logic  tick_valid_reg;
    logic  tick_valid_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  advance;
    logic  tick_fire;
    logic  step_fire;

    logic                      cycle_phase_reg;
    logic                      cycle_phase_next;
    logic [HighCountWidth-1:0] high_count_reg;
    logic [HighCountWidth-1:0] high_count_next;
    logic [LowCountWidth-1:0]  low_count_reg;
    logic [LowCountWidth-1:0]  low_count_next;
    logic [ThresholdWidth-1:0] delay_count_reg;
    logic [ThresholdWidth-1:0] delay_count_next;
    logic                      s1_seen_reg;
    logic                      s1_seen_next;
    logic                      s2_seen_reg;
    logic                      s2_seen_next;
    logic [RelayCount-1:0]     relay_reg;
    logic [RelayCount-1:0]     relay_next;

    logic [32:0]               on_product;
    logic [LowCountWidth-1:0]  on_period;
    logic [HighCountWidth-1:0] off_period;
    logic [ThresholdWidth-1:0] delay_limit;
    logic                      phase_tick;

    // handshake
    assign advance   = !out_valid_reg || result.ready;
    assign step_fire = tick_valid_reg && advance;
    assign tick.ready = !tick_valid_reg || advance;
    assign tick_fire = tick.valid && tick.ready;

    assign tick_valid_next = tick_fire ? 1'b1 : (advance ? 1'b0 : tick_valid_reg);
    assign out_valid_next  = step_fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // derived periods
    assign on_product  = 33'(tick_reg.on_knob) * 33'(OnScale);
    assign on_period   = on_product[OnShift +: LowCountWidth];
    assign off_period  = HighCountWidth'(tick_reg.off_knob) * HighCountWidth'(OffScale);
    assign delay_limit = tick_reg.delay_knob[KnobWidth-1:1];
    assign phase_tick  = auto_enable_reg && !s1_seen_reg && !s2_seen_reg;

    always_comb
    begin
        relay_next       = relay_reg;
        cycle_phase_next = cycle_phase_reg;
        high_count_next  = high_count_reg;
        low_count_next   = low_count_reg;
        delay_count_next = delay_count_reg;
        s1_seen_next     = s1_seen_reg;
        s2_seen_next     = s2_seen_reg;

        // automatic cycle
        if (phase_tick)
        begin
            if (!cycle_phase_reg)
            begin
                relay_next[RelayOne]   = 1'b1;
                relay_next[RelayTwo]   = 1'b1;
                relay_next[RelayThree] = 1'b1;
                if (high_count_reg != '0)
                begin
                    high_count_next = high_count_reg - 1'b1;
                end
                else
                begin
                    high_count_next  = off_period;
                    cycle_phase_next = 1'b1;
                end
            end
            else
            begin
                relay_next[RelayOne]   = 1'b0;
                relay_next[RelayTwo]   = 1'b0;
                relay_next[RelayThree] = 1'b0;
                if (low_count_reg != '0)
                begin
                    low_count_next = low_count_reg - 1'b1;
                end
                else
                begin
                    low_count_next   = on_period;
                    cycle_phase_next = 1'b0;
                end
            end
        end

        // sensor one and delay count
        if (!tick_reg.sensor_one_level)
        begin
            relay_next[RelayThree] = 1'b1;
            s1_seen_next           = 1'b1;
            if (delay_count_reg < delay_limit)
            begin
                delay_count_next = delay_count_reg + 1'b1;
            end
        end
        else
        begin
            delay_count_next = '0;
            if (s1_seen_reg)
            begin
                relay_next[RelayThree] = 1'b0;
                s1_seen_next           = 1'b0;
            end
        end

        relay_next[RelayFour] = (delay_count_next >= delay_threshold_reg);

        // sensor two
        if (!tick_reg.sensor_two_level)
        begin
            relay_next[RelayOne]  = 1'b1;
            relay_next[RelayTwo]  = 1'b1;
            relay_next[RelayFive] = 1'b1;
            s2_seen_next          = 1'b1;
        end
        else if (s2_seen_reg)
        begin
            relay_next[RelayOne]  = 1'b0;
            relay_next[RelayTwo]  = 1'b0;
            relay_next[RelayFive] = 1'b0;
            s2_seen_next          = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enable_reg     <= 1'b1;
            delay_threshold_reg <= ThresholdReset;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_AUTO_ENABLE:     auto_enable_reg     <= cfg_data[0];
                CFG_DELAY_THRESHOLD: delay_threshold_reg <= cfg_data[ThresholdWidth-1:0];
                default:             auto_enable_reg     <= auto_enable_reg;
            endcase
        end
    end

    // tick register payload
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            tick_reg.on_knob          <= tick.on_knob;
            tick_reg.off_knob         <= tick.off_knob;
            tick_reg.delay_knob       <= tick.delay_knob;
            tick_reg.sensor_one_level <= tick.sensor_one_level;
            tick_reg.sensor_two_level <= tick.sensor_two_level;
        end
    end

    // control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            cycle_phase_reg <= 1'b0;
            high_count_reg  <= HighCountReset;
            low_count_reg   <= LowCountReset;
            delay_count_reg <= '0;
            s1_seen_reg     <= 1'b0;
            s2_seen_reg     <= 1'b0;
            relay_reg       <= '0;
        end
        else
        begin
            tick_valid_reg <= tick_valid_next;
            out_valid_reg  <= out_valid_next;
            if (step_fire)
            begin
                cycle_phase_reg <= cycle_phase_next;
                high_count_reg  <= high_count_next;
                low_count_reg   <= low_count_next;
                delay_count_reg <= delay_count_next;
                s1_seen_reg     <= s1_seen_next;
                s2_seen_reg     <= s2_seen_next;
                relay_reg       <= relay_next;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.relay_one   = relay_reg[RelayOne];
    assign result.relay_two   = relay_reg[RelayTwo];
    assign result.relay_three = relay_reg[RelayThree];
    assign result.relay_four  = relay_reg[RelayFour];
    assign result.relay_five  = relay_reg[RelayFive];

    `CRT_ASSERT_NEXT(a_s1_forces_relay3, clk, rst_n, step_fire && !tick_reg.sensor_one_level, result.valid && result.relay_three, "sensor one did not force relay three")
    `CRT_ASSERT_NEXT(a_s2_forces_relays, clk, rst_n, step_fire && !tick_reg.sensor_two_level, result.relay_one && result.relay_two && result.relay_five, "sensor two did not force its relays")
    `CRT_ASSERT_NEXT(a_s1_release_clears, clk, rst_n, step_fire && tick_reg.sensor_one_level, delay_count_reg == '0 && !s1_seen_reg, "sensor one release left delay state")
    `CRT_ASSERT_SAME(a_no_step_when_stalled, clk, rst_n, out_valid_reg && !result.ready, !step_fire && (!tick_valid_reg || !tick.ready), "step taken while result stalled")
    `CRT_ASSERT_NEXT(a_relay4_after_release, clk, rst_n, step_fire && tick_reg.sensor_one_level && delay_threshold_reg != '0 && !cfg_wr_en, !result.relay_four, "relay four on with no delay count")

endmodule
